[rtl/dmme_pkg.sv]
// Shared types and constants of the dense matrix multiply engine.
package dmme_pkg;

    localparam int CMD_W   = 2;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 7;
    localparam int K_W     = 6;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int SUM_W   = 38;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [ROW_W-1:0]          i_index;
        logic [COL_W-1:0]          j_index;
        logic [K_W-1:0]            k_index;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        column;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic operand_valid;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
    } mac_stat_t;

endpackage

[rtl/dmme_stream_if.sv]
// Valid/ready channel carrying one payload word per handshake.
interface dmme_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/dmme_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module dmme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/dmme_mac.sv]
// Shared multiply-accumulate unit: registered product, then 38-bit wrapping accumulate.
module dmme_mac (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  dmme_pkg::mac_ctrl_t                      ctrl,
    input  logic signed [dmme_pkg::VALUE_W-1:0]      a_operand,
    input  logic signed [dmme_pkg::VALUE_W-1:0]      b_operand,
    output dmme_pkg::mac_stat_t                      stat,
    output logic signed [dmme_pkg::SUM_W-1:0]        acc
);
    import dmme_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.operand_valid)
        begin
            prod_reg <= a_operand * b_operand;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.operand_valid;
            acc_reg      <= acc_next;
        end
    end

    assign stat.busy = prod_vld_reg;
    assign acc       = acc_reg;
endmodule

[rtl/dense_matrix_multiply_engine.sv]
// Top level of the dense matrix multiply engine, C = A x B on signed Q8.8 elements.
//
// Usage:
//   req carries command words: write A[i][k], write B[k][j], or compute C[i][j].
//   rsp carries one word per compute: exact Q22.16 sum, row and column.
//   A write gives no response; ready stays high, so writes
//   can follow back to back.
//   A compute reads A and B one term per cycle through the shared MAC: the RAMs
//   register each read, the MAC registers the product and then accumulates it,
//   and the sum loads into the response register once the MAC has drained.
//   A compute outside ROWS or COLS answers zero without reading the RAMs.
//   The rate is set by the single read port of each matrix RAM and the one MAC.
//   req.ready is low while a compute is in progress.
//   The response register decouples the sides: writes are accepted while a
//   response waits; a finished compute holds until rsp.ready frees the register.
//   Reset clears control state only; matrix RAM contents are undefined until
//   written, and no clearing pass runs.
module dense_matrix_multiply_engine #(
    parameter int ROWS  = 256,
    parameter int COLS  = 128,
    parameter int INNER = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    dmme_stream_if.sink   req,
    dmme_stream_if.source rsp
);
    import dmme_pkg::*;

    localparam int A_DEPTH = ROWS * INNER;
    localparam int B_DEPTH = INNER * COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int T_W     = (INNER > 1) ? $clog2(INNER) : 1;

    state_t            state_reg;
    state_t            state_next;
    logic [T_W-1:0]    t_reg;
    logic [A_AW-1:0]   a_addr_reg;
    logic [B_AW-1:0]   b_addr_reg;
    logic [ROW_W-1:0]  i_reg;
    logic [COL_W-1:0]  j_reg;
    logic              rd_vld_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg;

    req_t              req_word;
    logic              accept;
    logic              is_compute;
    logic              in_range;
    logic              a_we;
    logic              b_we;
    logic [A_AW-1:0]   a_waddr;
    logic [B_AW-1:0]   b_waddr;
    logic [VALUE_W-1:0] a_rdata;
    logic [VALUE_W-1:0] b_rdata;
    logic              t_last;
    logic              drained;
    logic              slot_free;
    logic              load_rsp;
    logic              issue;
    mac_ctrl_t         mac_ctrl;
    mac_stat_t         mac_stat;
    logic signed [SUM_W-1:0] acc;

    assign req_word   = req.data;
    assign accept     = req.valid && req.ready;
    assign is_compute = (req_word.cmd == CMD_COMPUTE);
    assign in_range   = (int'(req_word.i_index) < ROWS) && (int'(req_word.j_index) < COLS);
    assign t_last     = (t_reg == T_W'(INNER - 1));
    assign drained    = !rd_vld_reg && !mac_stat.busy;
    assign slot_free  = !rsp_valid_reg || rsp.ready;

    assign a_waddr = A_AW'(int'(req_word.i_index) * INNER + int'(req_word.k_index));
    assign b_waddr = B_AW'(int'(req_word.k_index) * COLS + int'(req_word.j_index));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_compute)
                begin
                    state_next = in_range ? ST_RUN : ST_FLUSH;
                end
            end
            ST_RUN:
            begin
                if (t_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (drained && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready              = 1'b0;
        issue                  = 1'b0;
        load_rsp               = 1'b0;
        a_we                   = 1'b0;
        b_we                   = 1'b0;
        mac_ctrl.clear         = 1'b0;
        mac_ctrl.operand_valid = rd_vld_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    case (req_word.cmd)
                        CMD_WRITE_A:
                        begin
                            a_we = (int'(req_word.i_index) < ROWS)
                                && (int'(req_word.k_index) < INNER);
                        end
                        CMD_WRITE_B:
                        begin
                            b_we = (int'(req_word.k_index) < INNER)
                                && (int'(req_word.j_index) < COLS);
                        end
                        CMD_COMPUTE:
                        begin
                            mac_ctrl.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
            end
            ST_FLUSH:
            begin
                load_rsp = drained && slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_compute)
        begin
            i_reg      <= req_word.i_index;
            j_reg      <= req_word.j_index;
            t_reg      <= '0;
            a_addr_reg <= A_AW'(int'(req_word.i_index) * INNER);
            b_addr_reg <= B_AW'(req_word.j_index);
        end
        else if (issue)
        begin
            t_reg      <= t_reg + T_W'(1);
            a_addr_reg <= a_addr_reg + A_AW'(1);
            b_addr_reg <= b_addr_reg + B_AW'(COLS);
        end
        if (load_rsp)
        begin
            rsp_data_reg.sum    <= acc;
            rsp_data_reg.row    <= i_reg;
            rsp_data_reg.column <= j_reg;
        end
    end

    dmme_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (A_DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (req_word.value),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    dmme_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (B_DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (req_word.value),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    dmme_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .a_operand (signed'(a_rdata)),
        .b_operand (signed'(b_rdata)),
        .stat      (mac_stat),
        .acc       (acc)
    );

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    a_clear_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctrl.clear |-> (!rd_vld_reg && !mac_stat.busy))
        else $error("accumulator cleared with terms in flight");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_rsp |-> (!rsp_valid_reg || rsp.ready))
        else $error("response register overwritten");

    a_issue_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> (rd_vld_reg && mac_ctrl.operand_valid))
        else $error("issued read lost before the multiplier");

    a_no_write_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (a_we || b_we) |-> (!issue && !rd_vld_reg && !mac_stat.busy))
        else $error("matrix write during a compute");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the matrix multiply engine, checked against shadow copies of A and B.
module testbench;

    import dmme_pkg::*;

    localparam int ROWS        = 256;
    localparam int COLS        = 128;
    localparam int INNER       = 64;
    localparam int TARGET      = 800;
    localparam int TAIL_WORDS  = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 30;
    localparam int IDLE_LIMIT  = 3000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req_word  = '0;
    logic rsp_ready = 1'b0;

    dmme_stream_if #(.payload_t(req_t)) req_if ();
    dmme_stream_if #(.payload_t(rsp_t)) rsp_if ();

    assign req_if.valid = req_valid;
    assign req_if.data  = req_word;
    assign rsp_if.ready = rsp_ready;

    dense_matrix_multiply_engine #(
        .ROWS  (ROWS),
        .COLS  (COLS),
        .INNER (INNER)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    req_t cmd_words[$];
    rsp_t expected_sums[$];

    logic signed [VALUE_W-1:0] a_shadow [ROWS*INNER];
    logic signed [VALUE_W-1:0] b_shadow [INNER*COLS];

    bit a_written [ROWS*INNER];
    bit b_written [INNER*COLS];
    int a_row_fill [ROWS];
    int b_col_fill [COLS];
    int full_rows[$];
    int full_cols[$];

    int words_accepted = 0;
    int writes_seen    = 0;
    int computes_seen  = 0;
    int sums_checked   = 0;
    int error_count    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int idle_cycles    = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return VALUE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input int i, input int j,
                              input int k, input logic [VALUE_W-1:0] v);
        req_t w;
        w.cmd     = cmd;
        w.i_index = ROW_W'(i);
        w.j_index = COL_W'(j);
        w.k_index = K_W'(k);
        w.value   = v;
        cmd_words.push_back(w);
        if (cmd == CMD_WRITE_A && !a_written[i*INNER+k])
        begin
            a_written[i*INNER+k] = 1'b1;
            a_row_fill[i]++;
            if (a_row_fill[i] == INNER)
                full_rows.push_back(i);
        end
        if (cmd == CMD_WRITE_B && !b_written[k*COLS+j])
        begin
            b_written[k*COLS+j] = 1'b1;
            b_col_fill[j]++;
            if (b_col_fill[j] == INNER)
                full_cols.push_back(j);
        end
    endtask

    task automatic fill_line(input logic [CMD_W-1:0] cmd, input int line, input bit rand_values,
                             input logic [VALUE_W-1:0] v);
        int k0;
        int n;
        int k;
        k0 = $urandom_range(0, INNER-1);
        for (n = 0; n < INNER; n++)
        begin
            k = (k0 + n) % INNER;
            if (cmd == CMD_WRITE_A)
                queue_word(cmd, line, $urandom_range(0, COLS-1), k,
                           rand_values ? pick_value() : v);
            else
                queue_word(cmd, $urandom_range(0, ROWS-1), line, k,
                           rand_values ? pick_value() : v);
        end
    endtask

    task automatic queue_compute(input int i, input int j);
        queue_word(CMD_COMPUTE, i, j, $urandom_range(0, INNER-1), VALUE_W'($urandom));
    endtask

    function automatic rsp_t dot_product(input req_t w);
        rsp_t   r;
        longint acc;
        acc = 0;
        if (w.i_index < ROWS && w.j_index < COLS)
            for (int t = 0; t < INNER; t++)
                acc += longint'(a_shadow[w.i_index*INNER+t]) *
                       longint'(b_shadow[t*COLS+w.j_index]);
        r.sum    = acc[SUM_W-1:0];
        r.row    = w.i_index;
        r.column = w.j_index;
        return r;
    endfunction

    task automatic apply_word(input req_t w);
        case (w.cmd)
            CMD_WRITE_A:
            begin
                if (w.i_index < ROWS && w.k_index < INNER)
                    a_shadow[w.i_index*INNER+w.k_index] = w.value;
                writes_seen++;
            end
            CMD_WRITE_B:
            begin
                if (w.k_index < INNER && w.j_index < COLS)
                    b_shadow[w.k_index*COLS+w.j_index] = w.value;
                writes_seen++;
            end
            CMD_COMPUTE:
            begin
                expected_sums.push_back(dot_product(w));
                computes_seen++;
            end
            default:
                ;
        endcase
    endtask

    task automatic check_sum(input rsp_t got);
        rsp_t want;
        if (expected_sums.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual sum=%0d row=%0d column=%0d",
                     $time, got.sum, got.row, got.column);
            error_count++;
        end
        else
        begin
            want = expected_sums.pop_front();
            sums_checked++;
            if (got.sum !== want.sum)
            begin
                $display("%0t: C[%0d][%0d] sum expected %0d, actual %0d",
                         $time, want.row, want.column, want.sum, got.sum);
                error_count++;
            end
            if (got.row !== want.row)
            begin
                $display("%0t: row expected %0d, actual %0d", $time, want.row, got.row);
                error_count++;
            end
            if (got.column !== want.column)
            begin
                $display("%0t: column expected %0d, actual %0d", $time, want.column, got.column);
                error_count++;
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            if (req_valid && req_if.ready)
            begin
                apply_word(req_word);
                words_accepted <= words_accepted + 1;
            end
            if (!req_valid || req_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (cmd_words.size() == 0)
                    req_valid <= 1'b0;
                else if (cmd_words.size() > TAIL_WORDS && (cmd_words.size() % 150) >= 40
                         && $urandom_range(0, 7) == 0)
                begin
                    gap_left  <= $urandom_range(0, 7);
                    req_valid <= 1'b0;
                end
                else
                begin
                    req_word  <= cmd_words.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                check_sum(rsp_if.data);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && sums_checked >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_ready  <= 1'b0;
            end
            else if (cmd_words.size() > TAIL_WORDS && (sums_checked % 16) >= 4
                     && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 7);
                rsp_ready  <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("dense_matrix_multiply_engine test failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int i;
        int j;

        // extremes of the sum: full-scale rows and columns
        fill_line(CMD_WRITE_A, 0,         1'b0, 16'h8000);
        fill_line(CMD_WRITE_A, ROWS-1,    1'b0, 16'h7FFF);
        fill_line(CMD_WRITE_B, 0,         1'b0, 16'h8000);
        fill_line(CMD_WRITE_B, COLS-1,    1'b0, 16'h7FFF);
        queue_compute(0, 0);
        queue_compute(ROWS-1, COLS-1);
        queue_compute(0, COLS-1);
        queue_compute(ROWS-1, 0);
        // unused command must leave the stores alone
        queue_word(CMD_UNUSED, 0, 0, 0, 16'h7FFF);
        queue_word(CMD_UNUSED, ROWS-1, COLS-1, INNER-1, 16'hFFFF);
        queue_compute(0, 0);
        queue_word(CMD_WRITE_A, 0, COLS-1, 0, 16'h0000);
        queue_word(CMD_WRITE_B, ROWS-1, COLS-1, INNER-1, 16'hFFFF);
        queue_word(CMD_WRITE_A, ROWS-1, 0, 5, 16'h0100);
        queue_word(CMD_WRITE_B, 0, 0, INNER-1, 16'h0001);
        queue_compute(0, 0);
        queue_compute(ROWS-1, COLS-1);
        queue_compute(0, COLS-1);

        while (cmd_words.size() < TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
            begin
                do i = $urandom_range(0, ROWS-1); while (a_row_fill[i] == INNER);
                fill_line(CMD_WRITE_A, i, 1'b1, '0);
            end
            else if (r < 2)
            begin
                do j = $urandom_range(0, COLS-1); while (b_col_fill[j] == INNER);
                fill_line(CMD_WRITE_B, j, 1'b1, '0);
            end
            else if (r < 20)
                queue_word(CMD_WRITE_A, full_rows[$urandom_range(0, full_rows.size()-1)],
                           $urandom_range(0, COLS-1), $urandom_range(0, INNER-1), pick_value());
            else if (r < 38)
                queue_word(CMD_WRITE_B, $urandom_range(0, ROWS-1),
                           full_cols[$urandom_range(0, full_cols.size()-1)],
                           $urandom_range(0, INNER-1), pick_value());
            else if (r < 48)
                queue_word($urandom_range(0, 1) ? CMD_WRITE_A : CMD_WRITE_B,
                           $urandom_range(0, ROWS-1), $urandom_range(0, COLS-1),
                           $urandom_range(0, INNER-1), pick_value());
            else if (r < 51)
                queue_word(CMD_UNUSED, $urandom_range(0, ROWS-1), $urandom_range(0, COLS-1),
                           $urandom_range(0, INNER-1), VALUE_W'($urandom));
            else
                queue_compute(full_rows[$urandom_range(0, full_rows.size()-1)],
                              full_cols[$urandom_range(0, full_cols.size()-1)]);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_words.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (INNER + 16) @(posedge clk);

        $display("Drove %0d request words: %0d element writes and %0d dot products.",
                 words_accepted, writes_seen, computes_seen);
        $display("Checked %0d result words across %0d full rows and %0d full columns.",
                 sums_checked, full_rows.size(), full_cols.size());
        if (error_count == 0)
            $display("dense_matrix_multiply_engine test passed");
        else
            $display("dense_matrix_multiply_engine test failed");
        $finish;
    end

endmodule
